// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: same-cycle property");

// Check that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle property");

`endif

// File: hdl/ccts_pkg.sv
// Types and constants of the capacitive charge-time sensor.
package ccts_pkg;

   localparam int CMD_W     = 2;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;
   localparam int TENTH_W   = 29;

   // Commands
   localparam logic [CMD_W-1:0] CMD_BASELINED = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RAW       = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AUTOCAL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DISCHARGE = 2'd2;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_TIMEOUT = 1'b1;

   // Register reset values
   localparam logic [31:0] TIMEOUT_RESET   = 32'd1860000;
   localparam logic [31:0] AUTOCAL_RESET   = 32'hFFFF_FFFF;
   localparam logic [15:0] DISCHARGE_RESET = 16'd100;

   // Baseline floor and its tenth
   localparam logic [31:0]        FLOOR_RESET = 32'h0FFF_FFFF;
   localparam logic [TENTH_W-1:0] TENTH_RESET = TENTH_W'(FLOOR_RESET / 10);
   localparam logic [31:0]        RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 TENTH_SHIFT = 35;
   localparam logic [31:0]        MS_MAX      = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_DISCHARGE = 3'd1,
      PH_CHARGE    = 3'd2,
      PH_RECHARGE  = 3'd3,
      PH_DRAIN     = 3'd4
   } phase_type;

   typedef struct packed {
      logic [31:0] timeout_count;
      logic [31:0] autocal_interval_ms;
      logic [15:0] discharge_ticks;
   } ccts_cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COUNT_W-1:0] sample_count;
      logic               rx_level;
      logic               ms_strobe;
   } ccts_req_type;

   typedef struct packed {
      logic        tx_level;
      logic        rx_drive_enable;
      logic        rx_drive_level;
      logic        busy_res;
      logic        done_res;
      logic        status;
      logic [31:0] reading;
   } ccts_rsp_type;

endpackage

// File: hdl/ccts_req_if.sv
// Input channel: one tick word with valid/ready handshake.
interface ccts_req_if;
   import ccts_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [COUNT_W-1:0] sample_count;
   logic               rx_level;
   logic               ms_strobe;

   modport source (output valid, command, sample_count, rx_level, ms_strobe,
                   input ready);
   modport sink (input valid, command, sample_count, rx_level, ms_strobe,
                 output ready);
endinterface

// File: hdl/ccts_rsp_if.sv
// Result channel: pin levels and measurement status with valid/ready handshake.
interface ccts_rsp_if;
   logic        valid;
   logic        ready;
   logic        tx_level;
   logic        rx_drive_enable;
   logic        rx_drive_level;
   logic        busy_res;
   logic        done_res;
   logic        status;
   logic [31:0] reading;

   modport source (output valid, tx_level, rx_drive_enable, rx_drive_level, busy_res,
                   done_res, status, reading,
                   input ready);
   modport sink (input valid, tx_level, rx_drive_enable, rx_drive_level, busy_res,
                 done_res, status, reading,
                 output ready);
endinterface

// File: hdl/ccts_cfg.sv
// Configuration registers written through the plain write port.
module ccts_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [ccts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ccts_pkg::CSR_W-1:0]     csr_wdata,
   output ccts_pkg::ccts_cfg_type         cfg
);
   import ccts_pkg::*;

   logic [31:0] timeout_ff;
   logic [31:0] autocal_ff;
   logic [15:0] discharge_ff;

   // Update the addressed register; drop writes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         autocal_ff   <= AUTOCAL_RESET;
         discharge_ff <= DISCHARGE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_TIMEOUT:   timeout_ff   <= csr_wdata;
            REG_AUTOCAL:   autocal_ff   <= csr_wdata;
            REG_DISCHARGE: discharge_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg.timeout_count       = timeout_ff;
   assign cfg.autocal_interval_ms = autocal_ff;
   assign cfg.discharge_ticks     = discharge_ff;
endmodule

// File: hdl/ccts_in_reg.sv
// Input register: holds one tick word until the core consumes it.
module ccts_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   ccts_req_if.sink               req_if,
   input  logic                   out_free,
   output logic                   step,
   output ccts_pkg::ccts_req_type item
);
   import ccts_pkg::*;

   logic         valid_ff;
   ccts_req_type item_ff;

   // Advance when a word is held and the result register can take it
   assign step         = valid_ff && out_free;
   assign req_if.ready = !valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         valid_ff <= req_if.valid;
      end
   end

   // Capture the payload on accept
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         item_ff.command      <= req_if.command;
         item_ff.sample_count <= req_if.sample_count;
         item_ff.rx_level     <= req_if.rx_level;
         item_ff.ms_strobe    <= req_if.ms_strobe;
      end
   end

   assign item = item_ff;
endmodule

// File: hdl/ccts_core.sv
// Measurement core: phase sequencer, tick accumulation and baseline tracking.
module ccts_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ccts_pkg::ccts_req_type item,
   input  ccts_pkg::ccts_cfg_type cfg,
   output ccts_pkg::ccts_rsp_type result
);
   import ccts_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [31:0]        total_ff, total_in;
   logic [31:0]        floor_ff, floor_in;
   logic [TENTH_W-1:0] tenth_ff;
   logic [31:0]        ms_ff, ms_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [15:0]        timer_ff, timer_in;
   logic               raw_ff, raw_in;

   logic        start;
   logic        disch_end;
   logic        below_limit;
   logic        over_limit;
   logic        charge_count;
   logic        drain_count;
   logic        last_sample;
   logic [31:0] ms_inc;
   logic [31:0] diff;
   logic        recal;
   logic [31:0] floor_mid;
   logic        total_low;
   logic [63:0] tenth_prod;

   // Decode the current tick
   always_comb begin
      start        = (item.command == CMD_BASELINED) || (item.command == CMD_RAW);
      disch_end    = ({1'b0, timer_ff} + 17'd1) >= {1'b0, cfg.discharge_ticks};
      below_limit  = total_ff < cfg.timeout_count;
      over_limit   = total_ff > cfg.timeout_count;
      charge_count = !item.rx_level && below_limit;
      drain_count  = item.rx_level && below_limit;
      last_sample  = left_ff == COUNT_W'(1);
      ms_inc       = (item.ms_strobe && ms_ff != MS_MAX) ? ms_ff + 32'd1 : ms_ff;
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start && item.sample_count != '0) begin
               phase_in = PH_DISCHARGE;
            end
         end
         PH_DISCHARGE: begin
            if (disch_end) begin
               phase_in = PH_CHARGE;
            end
         end
         PH_CHARGE: begin
            if (charge_count) begin
               phase_in = PH_CHARGE;
            end else if (over_limit) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_RECHARGE;
            end
         end
         PH_RECHARGE: phase_in = PH_DRAIN;
         PH_DRAIN: begin
            if (drain_count) begin
               phase_in = PH_DRAIN;
            end else if (!below_limit || last_sample) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_DISCHARGE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Baseline check on a good end of measurement
   always_comb begin
      diff      = (total_ff > floor_ff) ? total_ff - floor_ff : floor_ff - total_ff;
      recal     = (ms_inc > cfg.autocal_interval_ms) && (diff < {3'b000, tenth_ff});
      floor_mid = recal ? FLOOR_RESET : floor_ff;
      total_low = total_ff < floor_mid;
   end

   // Datapath updates and result fields
   always_comb begin
      total_in = total_ff;
      floor_in = floor_ff;
      ms_in    = ms_inc;
      left_in  = left_ff;
      timer_in = timer_ff;
      raw_in   = raw_ff;
      result.done_res = 1'b0;
      result.status   = STATUS_OK;
      result.reading  = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               total_in = '0;
               raw_in   = item.command == CMD_RAW;
               if (item.sample_count == '0) begin
                  result.done_res = 1'b1;
               end else begin
                  left_in  = item.sample_count;
                  timer_in = '0;
               end
            end
         end
         PH_DISCHARGE: begin
            timer_in = disch_end ? 16'd0 : timer_ff + 16'd1;
         end
         PH_CHARGE: begin
            if (charge_count) begin
               total_in = total_ff + 32'd1;
            end else if (over_limit) begin
               result.done_res = 1'b1;
               result.status   = STATUS_TIMEOUT;
            end
         end
         PH_RECHARGE: ;
         PH_DRAIN: begin
            if (drain_count) begin
               total_in = total_ff + 32'd1;
            end else if (!below_limit) begin
               result.done_res = 1'b1;
               result.status   = STATUS_TIMEOUT;
            end else begin
               left_in = left_ff - COUNT_W'(1);
               if (last_sample) begin
                  result.done_res = 1'b1;
                  if (raw_ff) begin
                     result.reading = total_ff;
                  end else begin
                     if (recal) begin
                        ms_in = '0;
                     end
                     floor_in       = total_low ? total_ff : floor_mid;
                     result.reading = total_low ? 32'd0 : total_ff - floor_mid;
                  end
               end else begin
                  timer_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // Pin levels follow the phase reached at the end of the tick
   always_comb begin
      result.tx_level        = phase_in == PH_CHARGE;
      result.rx_drive_enable = (phase_in == PH_DISCHARGE) || (phase_in == PH_RECHARGE);
      result.rx_drive_level  = phase_in == PH_RECHARGE;
      result.busy_res        = phase_in != PH_IDLE;
   end

   // Tenth of the floor by reciprocal multiply, refreshed every cycle
   assign tenth_prod = floor_ff * RECIP_TEN;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         total_ff <= '0;
         floor_ff <= FLOOR_RESET;
         tenth_ff <= TENTH_RESET;
         ms_ff    <= '0;
         left_ff  <= '0;
         timer_ff <= '0;
         raw_ff   <= 1'b0;
      end else begin
         tenth_ff <= tenth_prod[63:TENTH_SHIFT];
         if (step) begin
            phase_ff <= phase_in;
            total_ff <= total_in;
            floor_ff <= floor_in;
            ms_ff    <= ms_in;
            left_ff  <= left_in;
            timer_ff <= timer_in;
            raw_ff   <= raw_in;
         end
      end
   end
endmodule

// File: hdl/ccts_out_reg.sv
// Result register: holds one result word until the sink takes it.
module ccts_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ccts_pkg::ccts_rsp_type result,
   output logic                   out_free,
   ccts_rsp_if.source             rsp_if
);
   import ccts_pkg::*;

   logic         valid_ff;
   ccts_rsp_type data_ff;

   // Free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Load the new result word
   always_ff @(posedge clock) begin
      if (step) begin
         data_ff <= result;
      end
   end

   assign rsp_if.valid           = valid_ff;
   assign rsp_if.tx_level        = data_ff.tx_level;
   assign rsp_if.rx_drive_enable = data_ff.rx_drive_enable;
   assign rsp_if.rx_drive_level  = data_ff.rx_drive_level;
   assign rsp_if.busy_res        = data_ff.busy_res;
   assign rsp_if.done_res        = data_ff.done_res;
   assign rsp_if.status          = data_ff.status;
   assign rsp_if.reading         = data_ff.reading;
endmodule

// File: hdl/capacitive_charge_time_sensor.sv
// Path: input register, then core, then result register and result port.
// Throughput: one tick word per cycle without stalls; each word gets one result word.
// The rate is set by the core's combinational update of phase, count and baseline.
// Stalls on the result side hold the result register and then the input register.
// Reset is synchronous, active high: idle phase, zero count, floor 0x0FFFFFFF.
module capacitive_charge_time_sensor (
   input  logic                           clock,
   input  logic                           reset,
   ccts_req_if.sink                       req_if,
   ccts_rsp_if.source                     rsp_if,
   input  logic                           csr_write_en,
   input  logic [ccts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ccts_pkg::CSR_W-1:0]     csr_wdata
);
   import ccts_pkg::*;

   ccts_cfg_type cfg;
   ccts_req_type item;
   ccts_rsp_type result;
   logic         step;
   logic         out_free;

   ccts_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ccts_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .out_free (out_free),
      .step     (step),
      .item     (item)
   );

   ccts_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   ccts_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .result   (result),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );
endmodule

// File: hdl/ccts_checker.sv
// Port-level checks on the sensor's result channel, bound to the top level.
`include "assert_macros.svh"

module ccts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        tx_level,
   input logic        rx_drive_enable,
   input logic        rx_drive_level,
   input logic        busy_res,
   input logic        done_res,
   input logic        status,
   input logic [31:0] reading
);
   // Stalled result word stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(reading) && $stable(done_res) && $stable(busy_res))

   // Result word leaves only when taken
   `ASSERT_ALWAYS(a_rsp_drop, clock, reset, !$fell(rsp_valid) || $past(rsp_ready))

   // A finished measurement leaves the block idle with pins released
   `ASSERT_ALWAYS(a_done_idle, clock, reset, !(rsp_valid && done_res) || (!busy_res && !tx_level && !rx_drive_enable))

   // Receive pin is driven high only while driven
   `ASSERT_ALWAYS(a_rx_drive, clock, reset, !(rsp_valid && rx_drive_level) || (rx_drive_enable && busy_res))

   // Timeout and idle ticks carry no reading
   `ASSERT_ALWAYS(a_no_reading, clock, reset, !(rsp_valid && (status || !done_res)) || (reading == 32'd0))
endmodule

bind capacitive_charge_time_sensor ccts_checker u_ccts_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .tx_level        (rsp_if.tx_level),
   .rx_drive_enable (rsp_if.rx_drive_enable),
   .rx_drive_level  (rsp_if.rx_drive_level),
   .busy_res        (rsp_if.busy_res),
   .done_res        (rsp_if.done_res),
   .status          (rsp_if.status),
   .reading         (rsp_if.reading)
);
